// File: rtl/core/lcsp_pkg.sv
// ----------------------------------------------------------------------------
// lcsp_pkg: shared types and constants of the LED-cube shape pattern block
// Holds the pattern mode codes, register indexes and the animation state
// word that travels from the animation sequencer to the voxel evaluator.
// ----------------------------------------------------------------------------
package lcsp_pkg;

    // Pattern modes
    localparam logic [2:0] MODE_CORNERS  = 3'd0;
    localparam logic [2:0] MODE_EDGES    = 3'd1;
    localparam logic [2:0] MODE_SOLID    = 3'd2;
    localparam logic [2:0] MODE_SHELLS   = 3'd3;
    localparam logic [2:0] MODE_HYPER    = 3'd4;
    localparam logic [3:0] MODE_COUNT    = 4'd5;

    // Largest size step
    localparam logic [1:0] STEP_MAX      = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_HOLD_STILL      = 2'd0;
    localparam logic [1:0] REG_START_MODE      = 2'd1;
    localparam logic [1:0] REG_CYCLES_PER_MODE = 2'd2;

    // Configuration register contents
    typedef struct packed {
        logic       hold_still;
        logic [2:0] start_mode;
        logic [7:0] cycles_per_mode;
    } t_cfg;

    // Animation state that applies to the word under evaluation
    typedef struct packed {
        logic [1:0] step;
        logic [2:0] mode;
    } t_anim;

endpackage

// File: rtl/core/lcsp_anim.sv
// ----------------------------------------------------------------------------
// lcsp_anim: animation sequencer
// Applies a restart to the step, direction, bounce count and mode, hands the
// resulting step and mode to the evaluator, and advances them on a frame end.
// ----------------------------------------------------------------------------
module lcsp_anim (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lcsp_pkg::t_cfg  i_cfg,
    input  logic          i_accept,
    input  logic          i_restart,
    input  logic          i_frame_end,
    output lcsp_pkg::t_anim o_anim
);
    import lcsp_pkg::*;

    logic [1:0] r_step;
    logic       r_direction;
    logic [2:0] r_mode;
    logic [7:0] r_bounce_count;

    logic [1:0] n_step;
    logic       n_direction;
    logic [2:0] n_mode;
    logic [7:0] n_bounce_count;

    logic [1:0] e_step;
    logic       e_direction;
    logic [2:0] e_mode;
    logic [7:0] e_bounce_count;
    logic [7:0] bounce_inc;
    logic [3:0] mode_inc;

    // Apply restart ahead of evaluation
    always_comb begin
        if (i_restart) begin
            e_step         = i_cfg.hold_still ? STEP_MAX : 2'd0;
            e_direction    = 1'b0;
            e_bounce_count = 8'd0;
            e_mode         = i_cfg.hold_still ? i_cfg.start_mode : MODE_CORNERS;
        end else begin
            e_step         = r_step;
            e_direction    = r_direction;
            e_bounce_count = r_bounce_count;
            e_mode         = r_mode;
        end
    end

    assign o_anim.step = e_step;
    assign o_anim.mode = e_mode;

    assign bounce_inc = e_bounce_count + 8'd1;
    assign mode_inc   = {1'b0, e_mode} + 4'd1;

    // Advance the ping-pong step and the mode after a frame
    always_comb begin
        n_step         = e_step;
        n_direction    = e_direction;
        n_bounce_count = e_bounce_count;
        n_mode         = e_mode;
        if (i_frame_end && !i_cfg.hold_still) begin
            priority if (e_step == STEP_MAX && !e_direction) begin
                n_direction = 1'b1;
            end else if (e_step == 2'd0 && e_direction) begin
                n_direction = 1'b0;
                if (bounce_inc == i_cfg.cycles_per_mode) begin
                    n_bounce_count = 8'd0;
                    n_mode = (mode_inc >= MODE_COUNT) ? 3'(mode_inc - MODE_COUNT)
                                                      : mode_inc[2:0];
                end else begin
                    n_bounce_count = bounce_inc;
                end
            end else if (!e_direction) begin
                n_step = e_step + 2'd1;
            end else begin
                n_step = e_step - 2'd1;
            end
        end
    end

    // Hold state between accepted words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step         <= 2'd0;
            r_direction    <= 1'b0;
            r_mode         <= MODE_CORNERS;
            r_bounce_count <= 8'd0;
        end else if (i_accept) begin
            r_step         <= n_step;
            r_direction    <= n_direction;
            r_mode         <= n_mode;
            r_bounce_count <= n_bounce_count;
        end
    end

    // State moves only on an accepted word
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_step) && $stable(r_mode) && $stable(r_direction)
                      && $stable(r_bounce_count))
        else $error("animation state changed without an accepted word");

    // Holding still freezes step and mode unless a restart reloads them
    a_hold_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_cfg.hold_still && !i_restart |=> $stable(r_step) && $stable(r_mode))
        else $error("animation advanced while holding still");

    // A plain restart without frame end lands on step zero, mode zero
    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_restart && !i_cfg.hold_still && !i_frame_end
        |=> r_step == 2'd0 && r_mode == MODE_CORNERS && r_bounce_count == 8'd0)
        else $error("restart did not clear the animation");

endmodule

// File: rtl/core/lcsp_eval.sv
// ----------------------------------------------------------------------------
// lcsp_eval: voxel evaluator
// Decides from the voxel coordinates, the mode and the size step whether
// the voxel is lit. Pure compare logic on 3-bit coordinates (x is 2 bits, zero-extended).
// ----------------------------------------------------------------------------
module lcsp_eval (
    input  logic [1:0]      i_x_pos,
    input  logic [2:0]      i_y_pos,
    input  logic [2:0]      i_z_pos,
    input  lcsp_pkg::t_anim i_anim,
    output logic            o_voxel_on
);
    import lcsp_pkg::*;

    // Coordinate inside the span 3-k .. 4+k
    function automatic logic in_span(input logic [2:0] p, input logic [1:0] k);
        logic [2:0] lo;
        logic [2:0] hi;
        lo = 3'd3 - {1'b0, k};
        hi = 3'd4 + {1'b0, k};
        return (p >= lo) && (p <= hi);
    endfunction

    // Inside the span and outside its hollow middle
    function automatic logic corner_axis(input logic [2:0] p, input logic [1:0] k);
        logic [2:0] lo;
        logic [2:0] hi;
        lo = 3'd4 - {1'b0, k};
        hi = 3'd3 + {1'b0, k};
        return in_span(p, k) && ((k == 2'd0) || !((p > lo) && (p < hi)));
    endfunction

    // Coordinate on one of the two faces of size k
    function automatic logic on_diag(input logic [2:0] p, input logic [1:0] k);
        return (p == 3'd3 - {1'b0, k}) || (p == 3'd4 + {1'b0, k});
    endfunction

    function automatic logic edge_pair(input logic [2:0] a, input logic [2:0] b,
                                       input logic [1:0] k);
        return in_span(a, k) && on_diag(b, k);
    endfunction

    // Ring of size k in the a-b plane; the next smaller span is empty at k zero
    function automatic logic shell_pair(input logic [2:0] a, input logic [2:0] b,
                                        input logic [1:0] k);
        logic inner;
        inner = (k != 2'd0) && in_span(a, k - 2'd1) && in_span(b, k - 2'd1);
        return in_span(a, k) && in_span(b, k) && !inner;
    endfunction

    function automatic logic on_outer(input logic [2:0] p);
        return (p == 3'd0) || (p == 3'd7);
    endfunction

    logic [2:0] x;
    logic [1:0] k;
    logic       sh_xy;
    logic       sh_yz;
    logic       sh_zx;
    logic [1:0] outer_cnt;
    logic [3:0] diag_hit;

    assign x = {1'b0, i_x_pos};
    assign k = i_anim.step;

    assign sh_xy = shell_pair(x, i_y_pos, k);
    assign sh_yz = shell_pair(i_y_pos, i_z_pos, k);
    assign sh_zx = shell_pair(i_z_pos, x, k);

    assign outer_cnt = 2'(on_outer(x)) + 2'(on_outer(i_y_pos)) + 2'(on_outer(i_z_pos));

    // Diagonal corners of every nested cube up to the current size
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            diag_hit[j] = (2'(j) <= k) && on_diag(x, 2'(j)) && on_diag(i_y_pos, 2'(j))
                          && on_diag(i_z_pos, 2'(j));
        end
    end

    // Select the pattern
    always_comb begin
        unique case (i_anim.mode)
            MODE_CORNERS: o_voxel_on = corner_axis(x, k) && corner_axis(i_y_pos, k)
                                       && corner_axis(i_z_pos, k);
            MODE_EDGES:   o_voxel_on = (edge_pair(x, i_y_pos, k) && edge_pair(x, i_z_pos, k))
                                    || (edge_pair(i_y_pos, x, k) && edge_pair(i_y_pos, i_z_pos, k))
                                    || (edge_pair(i_z_pos, x, k) && edge_pair(i_z_pos, i_y_pos, k));
            MODE_SOLID:   o_voxel_on = in_span(x, k) && in_span(i_y_pos, k)
                                       && in_span(i_z_pos, k);
            MODE_SHELLS:  o_voxel_on = (sh_xy && sh_yz) || (sh_yz && sh_zx) || (sh_zx && sh_xy);
            MODE_HYPER:   o_voxel_on = ((k == STEP_MAX) && (outer_cnt > 2'd1))
                                       || (|diag_hit);
            default:      o_voxel_on = 1'b0;
        endcase
    end

endmodule

// File: rtl/core/led_cube_shape_pattern.sv
// ----------------------------------------------------------------------------
// led_cube_shape_pattern: LED-cube voxel pattern generator
// The result of an accepted voxel word shows up on the master side in the next cycle.
// Throughput: 1 voxel per cycle; the single result register passes a word on
// while it takes the next one, so tready drops only while a result is stalled.
// Reset (i_rst_n low, synchronous) clears step, direction, mode, bounce count,
// hold_still and start_mode, sets cycles_per_mode to 1 and empties the output.
// ----------------------------------------------------------------------------
module led_cube_shape_pattern (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // Voxel stream in
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [1:0] x_pos, [4:2] y_pos, [7:5] z_pos
    input  logic       i_s_axis_tuser,  // [0] restart
    input  logic       i_s_axis_tlast,  // frame_end
    // Result stream out
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata   // [0] voxel_on, [7:1] zero
);
    import lcsp_pkg::*;

    t_cfg  r_cfg;
    t_anim anim;
    logic  accept;
    logic  voxel_on;
    logic  r_out_valid;
    logic  r_voxel_on;

    // Take configuration writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_still      <= 1'b0;
            r_cfg.start_mode      <= MODE_CORNERS;
            r_cfg.cycles_per_mode <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HOLD_STILL:      r_cfg.hold_still      <= i_cfg_data[0];
                REG_START_MODE:      r_cfg.start_mode      <= i_cfg_data[2:0];
                REG_CYCLES_PER_MODE: r_cfg.cycles_per_mode <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    // Accept while the result register is empty or draining
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    lcsp_anim u_anim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_restart   (i_s_axis_tuser),
        .i_frame_end (i_s_axis_tlast),
        .o_anim      (anim)
    );

    lcsp_eval u_eval (
        .i_x_pos    (i_s_axis_tdata[1:0]),
        .i_y_pos    (i_s_axis_tdata[4:2]),
        .i_z_pos    (i_s_axis_tdata[7:5]),
        .i_anim     (anim),
        .o_voxel_on (voxel_on)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_voxel_on <= voxel_on;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_voxel_on};

    // Every accepted word shows up as a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tvalid)
        else $error("accepted word produced no result");

    // Input stalls only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without a stalled result");

    // A taken result with nothing new behind it empties the register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !accept |=> !o_m_axis_tvalid)
        else $error("result repeated after it was taken");

endmodule
